[design/lkec_pkg.sv]
// Package with the command codes and controller interface types of the LRU keyed cache.
`default_nettype none
package lkec_pkg;

  localparam logic [1:0] CMD_PUT    = 2'd0;
  localparam logic [1:0] CMD_GET    = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;
  localparam logic [1:0] CMD_CLEAR  = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the input word and reset the scan state
    logic scan_rd;    // issue a read of the current scan slot
    logic scan_eval;  // evaluate the read data of the previous scan slot
    logic apply;      // commit the decision of the finished scan
    logic upd_rd;     // issue a read for the rank update pass
    logic upd_wr;     // write back the ranks for the update pass
    logic finish;     // load the output register
  } lkec_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_clear;
  } lkec_stat_t;

endpackage
`default_nettype wire

[design/lkec_ram.sv]
// Generic RAM with one write port, one read port and a registered read.
`default_nettype none
module lkec_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[design/lkec_ctrl.sv]
// Controller state machine that sequences the scan and rank update passes.
`default_nettype none
module lkec_ctrl #(
  parameter int ENTRIES = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 out_stall,
  output logic                      out_valid,
  input  wire lkec_pkg::lkec_stat_t stat,
  output lkec_pkg::lkec_cmd_t       cmd
);

  localparam int IW = $clog2(ENTRIES);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SCAN  = 5'b00010,
    ST_APPLY = 5'b00100,
    ST_UPD   = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  state_t        state, state_next;
  logic [IW:0]   cnt, cnt_next;
  logic          rd_pend, rd_pend_next;

  // Next state and command decode.
  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    rd_pend_next = 1'b0;
    cmd          = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid && !(out_valid && out_stall)) begin
          cmd.load   = 1'b1;
          state_next = ST_SCAN;
          cnt_next   = '0;
        end
      end
      ST_SCAN: begin
        if (stat.is_clear) begin
          state_next = ST_APPLY;
        end else begin
          cmd.scan_eval = rd_pend;
          if (cnt < (IW+1)'(ENTRIES)) begin
            cmd.scan_rd  = 1'b1;
            rd_pend_next = 1'b1;
            cnt_next     = cnt + 1'b1;
          end else begin
            state_next = ST_APPLY;
          end
        end
      end
      ST_APPLY: begin
        cmd.apply  = 1'b1;
        cnt_next   = '0;
        state_next = stat.is_clear ? ST_DONE : ST_UPD;
      end
      ST_UPD: begin
        cmd.upd_wr = rd_pend;
        if (cnt < (IW+1)'(ENTRIES)) begin
          cmd.upd_rd   = 1'b1;
          rd_pend_next = 1'b1;
          cnt_next     = cnt + 1'b1;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        cmd.finish = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      cnt     <= '0;
      rd_pend <= 1'b0;
    end else begin
      state   <= state_next;
      cnt     <= cnt_next;
      rd_pend <= rd_pend_next;
    end
  end

  // Output word register handshake.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  assign in_stall = !(state == ST_IDLE) || (out_valid && out_stall);

  a_one_hot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("controller state not one-hot");
  a_finish_from_done: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> state == ST_DONE) else $error("finish outside done state");
  a_out_valid_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.finish)) else $error("output word without finish");
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= (IW+1)'(ENTRIES)) else $error("scan counter out of range");

endmodule
`default_nettype wire

[design/lkec_dp.sv]
// Datapath with the slot memories, valid bits, scan logic and output register.
`default_nettype none
module lkec_dp #(
  parameter int ENTRIES = 64
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire lkec_pkg::lkec_cmd_t cmd,
  output lkec_pkg::lkec_stat_t     stat,
  input  wire logic [1:0]          in_cmd,
  input  wire logic [31:0]         in_key,
  input  wire logic [63:0]         in_ref,
  input  wire logic [15:0]         in_params,
  input  wire logic                out_stall,
  input  wire logic                out_valid,
  output logic                     hit,
  output logic [63:0]              found_ref,
  output logic [15:0]              found_params,
  output logic                     evicted,
  output logic [31:0]              evicted_key,
  output logic [6:0]               fill_level
);

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int RW = 112;

  // Captured input word.
  logic [1:0]  c_cmd;
  logic [31:0] c_key;
  logic [63:0] c_ref;
  logic [15:0] c_params;

  logic [ENTRIES-1:0] valid;
  logic [CW-1:0]      occ;

  // Scan results.
  logic          m_hit;
  logic [IW-1:0] m_idx;
  logic [IW-1:0] m_rank;
  logic          f_found;
  logic [IW-1:0] f_idx;
  logic          v_found;
  logic [IW-1:0] v_idx;
  logic [IW-1:0] v_rank;
  logic [31:0]   v_key;
  logic [63:0]   g_ref;
  logic [15:0]   g_params;

  // Rank update plan, fixed at apply.
  logic          pl_touch;   // ranks below pl_rank move back by one
  logic          pl_drop;    // ranks above pl_rank move forward by one
  logic          pl_ins;     // all valid ranks move back by one
  logic [IW-1:0] pl_rank;
  logic [IW-1:0] pl_slot;    // slot made most recent on a touch or insert, not shifted

  logic [IW:0]   scan_idx;
  logic [IW-1:0] eval_idx;

  // Memory ports.
  logic          kv_we, rk_we;
  logic [IW-1:0] kv_waddr, rk_waddr, raddr;
  logic [RW-1:0] kv_wdata, kv_rdata;
  logic [IW-1:0] rk_wdata, rk_rdata;

  assign stat.is_clear = (c_cmd == lkec_pkg::CMD_CLEAR);

  lkec_ram #(.WIDTH(RW), .DEPTH(ENTRIES)) u_kv (
    .clk, .we(kv_we), .waddr(kv_waddr), .wdata(kv_wdata), .raddr(raddr), .rdata(kv_rdata)
  );
  lkec_ram #(.WIDTH(IW), .DEPTH(ENTRIES)) u_rank (
    .clk, .we(rk_we), .waddr(rk_waddr), .wdata(rk_wdata), .raddr(raddr), .rdata(rk_rdata)
  );

  assign raddr = scan_idx[IW-1:0];

  wire [31:0] r_key    = kv_rdata[RW-1 -: 32];
  wire [63:0] r_ref    = kv_rdata[79:16];
  wire [15:0] r_params = kv_rdata[15:0];
  wire        r_valid  = valid[eval_idx];

  // Decision of the finished scan.
  logic          d_hit, d_evict, d_ins;
  logic [IW-1:0] d_slot;
  always_comb begin
    d_hit   = m_hit;
    d_evict = 1'b0;
    d_ins   = 1'b0;
    d_slot  = m_idx;
    if (!m_hit && c_cmd == lkec_pkg::CMD_PUT) begin
      d_ins = 1'b1;
      if (occ >= CW'(ENTRIES)) begin
        d_evict = v_found;
        d_slot  = v_idx;
      end else begin
        d_slot = f_idx;
      end
    end
  end

  // New rank of the slot read in the update pass.
  logic [IW-1:0] nr;
  always_comb begin
    nr = rk_rdata;
    if (eval_idx == pl_slot && (pl_touch || pl_ins)) begin
      nr = '0;
    end else if (pl_touch && rk_rdata < pl_rank) begin
      nr = rk_rdata + 1'b1;
    end else if (pl_drop && rk_rdata > pl_rank) begin
      nr = rk_rdata - 1'b1;
    end else if (pl_ins) begin
      nr = rk_rdata + 1'b1;
    end
  end

  always_comb begin
    kv_we    = cmd.apply && !stat.is_clear &&
               (d_ins || (d_hit && c_cmd == lkec_pkg::CMD_PUT));
    kv_waddr = d_slot;
    kv_wdata = {c_key, c_ref, c_params};
    rk_we    = cmd.upd_wr && valid[eval_idx];
    rk_waddr = eval_idx;
    rk_wdata = nr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      occ   <= '0;
    end else if (cmd.apply) begin
      if (stat.is_clear) begin
        valid <= '0;
        occ   <= '0;
      end else if (d_hit && c_cmd == lkec_pkg::CMD_REMOVE) begin
        valid[d_slot] <= 1'b0;
        occ           <= occ - 1'b1;
      end else if (d_ins && !d_evict) begin
        valid[d_slot] <= 1'b1;
        occ           <= occ + 1'b1;
      end
    end
  end

  // Capture, scan evaluation and update plan.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      c_cmd    <= in_cmd;
      c_key    <= in_key;
      c_ref    <= in_ref;
      c_params <= in_params;
      scan_idx <= '0;
      m_hit    <= 1'b0;
      f_found  <= 1'b0;
      v_found  <= 1'b0;
      m_idx    <= '0;
      m_rank   <= '0;
      f_idx    <= '0;
      v_idx    <= '0;
      v_rank   <= '0;
      v_key    <= '0;
      g_ref    <= '0;
      g_params <= '0;
    end
    if (cmd.scan_rd || cmd.upd_rd) begin
      eval_idx <= scan_idx[IW-1:0];
      scan_idx <= scan_idx + 1'b1;
    end
    if (cmd.scan_eval) begin
      if (r_valid && r_key == c_key && !m_hit) begin
        m_hit    <= 1'b1;
        m_idx    <= eval_idx;
        m_rank   <= rk_rdata;
        g_ref    <= r_ref;
        g_params <= r_params;
      end
      if (!r_valid && !f_found) begin
        f_found <= 1'b1;
        f_idx   <= eval_idx;
      end
      if (r_valid && (!v_found || rk_rdata > v_rank)) begin
        v_found <= 1'b1;
        v_idx   <= eval_idx;
        v_rank  <= rk_rdata;
        v_key   <= r_key;
      end
    end
    if (cmd.apply) begin
      scan_idx <= '0;
      pl_touch <= d_hit && c_cmd != lkec_pkg::CMD_REMOVE;
      pl_drop  <= d_hit && c_cmd == lkec_pkg::CMD_REMOVE;
      pl_ins   <= d_ins;
      pl_rank  <= m_rank;
      pl_slot  <= d_slot;
    end
  end

  // Output word register. An eviction reused the victim slot, so the insert
  // slot equals the victim only when the store was full.
  always_ff @(posedge clk) begin
    if (cmd.finish && !(out_valid && out_stall)) begin
      hit          <= !stat.is_clear && m_hit;
      found_ref    <= (!stat.is_clear && m_hit && c_cmd == lkec_pkg::CMD_GET) ? g_ref : '0;
      found_params <= (!stat.is_clear && m_hit && c_cmd == lkec_pkg::CMD_GET) ?
                      g_params : '0;
      evicted      <= !stat.is_clear && !m_hit && c_cmd == lkec_pkg::CMD_PUT &&
                      v_found && v_idx == pl_slot && pl_ins;
      evicted_key  <= (!stat.is_clear && !m_hit && c_cmd == lkec_pkg::CMD_PUT &&
                       v_found && v_idx == pl_slot && pl_ins &&
                       valid[pl_slot]) ? v_key : '0;
      fill_level   <= 7'(occ);
    end
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= CW'(ENTRIES)) else $error("occupancy above capacity");
  a_occ_count: assert property (@(posedge clk) disable iff (rst)
    occ == CW'($countones(valid))) else $error("occupancy does not match valid bits");
  a_ev_full: assert property (@(posedge clk) disable iff (rst)
    (cmd.apply && d_evict) |-> occ == CW'(ENTRIES)) else $error("eviction below capacity");

endmodule
`default_nettype wire

[design/lru_keyed_entry_cache_top.sv]
// Top level of the LRU keyed entry cache.
//
// Fully associative store of ENTRIES slots with least-recently-used replacement.
// The input channel carries one command word (cmd, entry_key, payload_ref,
// param_count) with in_valid/in_stall; the output channel returns exactly one
// result word per command with out_valid/out_stall.
// Each put, get or remove scans every slot through one read port of the slot
// memories, then a second pass over the rank memory rewrites recency ranks.
// A put, get or remove passes through the scan, apply, rank update and done
// states before its result word shows; a clear reads no slot and runs no rank
// update, going from scan straight to apply and done. One command is in work
// at a time.
// Reset clears the valid bits and the occupancy at once; no clearing pass.
// While the receiver stalls a result word, it holds and no new command is
// accepted until it is taken.
`default_nettype none
module lru_keyed_entry_cache_top #(
  parameter int ENTRIES = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  cmd,
  input  wire logic [31:0] entry_key,
  input  wire logic [63:0] payload_ref,
  input  wire logic [15:0] param_count,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             hit,
  output logic [63:0]      found_ref,
  output logic [15:0]      found_params,
  output logic             evicted,
  output logic [31:0]      evicted_key,
  output logic [6:0]       fill_level
);

  lkec_pkg::lkec_cmd_t  ctl;
  lkec_pkg::lkec_stat_t stat;

  lkec_ctrl #(.ENTRIES(ENTRIES)) u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_stall, .out_valid, .stat, .cmd(ctl)
  );

  lkec_dp #(.ENTRIES(ENTRIES)) u_dp (
    .clk, .rst, .cmd(ctl), .stat,
    .in_cmd(cmd), .in_key(entry_key), .in_ref(payload_ref), .in_params(param_count),
    .out_stall, .out_valid,
    .hit, .found_ref, .found_params, .evicted, .evicted_key, .fill_level
  );

endmodule
`default_nettype wire
